@@ rtl/hcwm_pkg.sv @@
// hcwm_pkg: shared constants and types for the hwb colour weighted mix core
`default_nettype none

package hcwm_pkg;

    // packed colour layout
    localparam int HUE_W   = 9;
    localparam int LEVEL_W = 7;
    localparam int ALPHA_W = 8;
    localparam int WGT_W   = 8;
    localparam int COLOUR_W = 32;
    localparam int MIXED_W  = 31;

    localparam logic [9:0]         FULL_ARC  = 10'h168;
    localparam logic [9:0]         HALF_ARC  = 10'hB4;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = 7'h7F;
    localparam logic [15:0]        ALPHA_ONE = 16'hFF00;
    localparam logic [WGT_W-1:0]   WGT_CAP   = 8'hFE;

    // divider: quotients stay below 2**DIV_BITS, dividends fit REM_W bits
    localparam int DIV_BITS = 9;
    localparam int PROD_W   = 16;
    localparam int REM_W    = PROD_W + DIV_BITS;

    // register stage indexes: input stage, operand stage, divider, output
    localparam int ST_OPER  = 1;
    localparam int ST_DIV0  = 2;
    localparam int ST_DIVN  = ST_DIV0 + DIV_BITS - 1;
    localparam int ST_OUT   = ST_DIVN + 1;

    // fields that ride along with the beat until the output stage
    typedef struct packed {
        logic [HUE_W-1:0]   hue_b;
        logic               neg;
        logic [LEVEL_W-1:0] white_a;
        logic [LEVEL_W-1:0] white_b;
        logic [LEVEL_W-1:0] black_a;
        logic [LEVEL_W-1:0] black_b;
        logic [ALPHA_W-1:0] alpha;
        logic [WGT_W-1:0]   weight;
    } t_carry;

endpackage

`default_nettype wire

@@ rtl/hcwm_if.sv @@
// hcwm_if: valid/ready channels for colour pairs in and mixed colours out
`default_nettype none

interface hcwm_in_if;
    logic                          valid;
    logic                          ready;
    logic [hcwm_pkg::COLOUR_W-1:0] colour_a;
    logic [hcwm_pkg::COLOUR_W-1:0] colour_b;
    logic [hcwm_pkg::WGT_W-1:0]    weight_in;

    modport source (output valid, colour_a, colour_b, weight_in, input ready);
    modport sink   (input valid, colour_a, colour_b, weight_in, output ready);
endinterface

interface hcwm_out_if;
    logic                         valid;
    logic                         ready;
    logic [hcwm_pkg::MIXED_W-1:0] mixed_colour;
    logic [hcwm_pkg::WGT_W-1:0]   weight_out;

    modport source (output valid, mixed_colour, weight_out, input ready);
    modport sink   (input valid, mixed_colour, weight_out, output ready);
endinterface

`default_nettype wire

@@ rtl/hwb_colour_weighted_mix_core.sv @@
// hwb_colour_weighted_mix_core: pipelined weighted mix of two packed hwba colours
//
//  channel  dir  handshake       payload
//  i_in     in   valid / ready   colour_a[31:0], colour_b[31:0], weight_in[7:0]
//  o_out    out  valid / ready   mixed_colour[30:0], weight_out[7:0]
//
// one beat per cycle in and out while the output channel is not stalled
// the 9-stage restoring divider (one quotient bit per stage) sets the depth
// the whole pipe advances together whenever the output register is empty or taken
// i_rst_n clears all stage valid bits; payload registers are not reset
`default_nettype none

module hwb_colour_weighted_mix_core (
    input  wire        i_clk,
    input  wire        i_rst_n,
    hcwm_in_if.sink    i_in,
    hcwm_out_if.source o_out
);

    localparam int RW = hcwm_pkg::REM_W;
    localparam int QW = hcwm_pkg::DIV_BITS;
    localparam int LW = hcwm_pkg::LEVEL_W;
    localparam int HW = hcwm_pkg::HUE_W;

    logic                       adv;
    logic [hcwm_pkg::ST_OUT:0]  r_vld;

    hcwm_pkg::t_carry           r_cry [0:hcwm_pkg::ST_DIVN];
    logic [QW-1:0]              r_mag;
    logic [hcwm_pkg::PROD_W-1:0] r_prod;
    logic [7:0]                 r_alpha_b;

    logic [hcwm_pkg::PROD_W-1:0] r_den  [hcwm_pkg::ST_OPER:hcwm_pkg::ST_DIVN];
    logic [RW-1:0]              r_rem1 [hcwm_pkg::ST_OPER:hcwm_pkg::ST_DIVN];
    logic [RW-1:0]              r_rem2 [hcwm_pkg::ST_OPER:hcwm_pkg::ST_DIVN];
    logic [QW-1:0]              r_q1   [hcwm_pkg::ST_OPER:hcwm_pkg::ST_DIVN];
    logic [QW-1:0]              r_q2   [hcwm_pkg::ST_OPER:hcwm_pkg::ST_DIVN];

    logic [hcwm_pkg::MIXED_W-1:0] r_mixed;
    logic [hcwm_pkg::WGT_W-1:0]   r_wout;

    assign adv         = !r_vld[hcwm_pkg::ST_OUT] || o_out.ready;
    // no beat is taken while reset is held
    assign i_in.ready  = adv && i_rst_n;
    assign o_out.valid = r_vld[hcwm_pkg::ST_OUT];
    assign o_out.mixed_colour = r_mixed;
    assign o_out.weight_out   = r_wout;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (adv) begin
            r_vld <= {r_vld[hcwm_pkg::ST_OUT-1:0], i_in.valid};
        end
    end

    // ---------------- stage 0: unpack, grey hue swap, arc offset, w*alpha_a
    logic [HW-1:0] s_hue_a, s_hue_b, s_ha, s_hb, s_diff, s_ra, s_rb;
    logic [LW-1:0] s_wa, s_wb, s_ba, s_bb;
    logic [7:0]    s_aa, s_ab, s_w;
    logic          s_grey_a, s_grey_b;
    logic [9:0]    s_off, s_pa, s_pb;
    logic [15:0]   s_inv;
    hcwm_pkg::t_carry n_cry0;

    always_comb begin
        s_hue_a = i_in.colour_a[30:22];
        s_hue_b = i_in.colour_b[30:22];
        s_wa    = i_in.colour_a[21:15];
        s_wb    = i_in.colour_b[21:15];
        s_ba    = i_in.colour_a[14:8];
        s_bb    = i_in.colour_b[14:8];
        s_aa    = i_in.colour_a[7:0];
        s_ab    = i_in.colour_b[7:0];
        s_grey_a = (s_wa == hcwm_pkg::LEVEL_MAX) || (s_ba == hcwm_pkg::LEVEL_MAX);
        s_grey_b = (s_wb == hcwm_pkg::LEVEL_MAX) || (s_bb == hcwm_pkg::LEVEL_MAX);
        s_ha    = s_grey_a ? s_hue_b : s_hue_a;
        s_hb    = s_grey_b ? s_ha : s_hue_b;
        s_diff  = (s_ha > s_hb) ? (s_ha - s_hb) : (s_hb - s_ha);
        s_off   = ({1'b0, s_diff} > hcwm_pkg::HALF_ARC) ? hcwm_pkg::HALF_ARC : 10'd0;
        // sums stay below twice the full arc, so one subtract reduces them
        s_pa    = {1'b0, s_ha} + s_off;
        s_pb    = {1'b0, s_hb} + s_off;
        s_ra    = (s_pa >= hcwm_pkg::FULL_ARC) ? HW'(s_pa - hcwm_pkg::FULL_ARC) : s_pa[HW-1:0];
        s_rb    = (s_pb >= hcwm_pkg::FULL_ARC) ? HW'(s_pb - hcwm_pkg::FULL_ARC) : s_pb[HW-1:0];
        s_w     = (i_in.weight_in == 8'd0) ? 8'd1 : i_in.weight_in;
        s_inv   = 16'(8'hFF - s_aa) * 16'(8'hFF - s_ab);

        n_cry0.hue_b   = s_hb;
        n_cry0.neg     = s_ra < s_rb;
        n_cry0.white_a = s_wa;
        n_cry0.white_b = s_wb;
        n_cry0.black_a = s_ba;
        n_cry0.black_b = s_bb;
        n_cry0.alpha   = 8'((hcwm_pkg::ALPHA_ONE - s_inv) >> 8);
        n_cry0.weight  = (s_w < hcwm_pkg::WGT_CAP) ? 8'(s_w + 8'd1) : s_w;
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cry[0]  <= n_cry0;
            r_mag     <= n_cry0.neg ? (s_rb - s_ra) : (s_ra - s_rb);
            r_prod    <= 16'(s_w) * 16'(s_aa);
            r_alpha_b <= s_ab;
        end
    end

    // ---------------- stage 1: denominator and both dividends
    logic [16:0] s_den;

    assign s_den = {1'b0, r_prod} + 17'(r_alpha_b);

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_cry[hcwm_pkg::ST_OPER] <= r_cry[0];
            // zero denominator only occurs with zero dividends: dividing by one gives zero
            r_den[hcwm_pkg::ST_OPER]  <= (s_den == 17'd0) ? 16'd1 : s_den[15:0];
            r_rem1[hcwm_pkg::ST_OPER] <= RW'(r_mag) * RW'(r_prod);
            r_rem2[hcwm_pkg::ST_OPER] <= RW'(hcwm_pkg::LEVEL_MAX) * RW'(r_prod);
            r_q1[hcwm_pkg::ST_OPER]   <= '0;
            r_q2[hcwm_pkg::ST_OPER]   <= '0;
        end
    end

    // ---------------- divider: one quotient bit per stage, msb first
    for (genvar j = hcwm_pkg::ST_DIV0; j <= hcwm_pkg::ST_DIVN; j++) begin : g_div
        localparam int BIT = hcwm_pkg::ST_DIVN - j;

        logic [RW-1:0] s_dsh;
        logic          s_ge1, s_ge2;
        logic [RW-1:0] n_rem1, n_rem2;
        logic [QW-1:0] n_q1, n_q2;

        always_comb begin
            s_dsh  = RW'(r_den[j-1]) << BIT;
            s_ge1  = r_rem1[j-1] >= s_dsh;
            s_ge2  = r_rem2[j-1] >= s_dsh;
            n_rem1 = s_ge1 ? (r_rem1[j-1] - s_dsh) : r_rem1[j-1];
            n_rem2 = s_ge2 ? (r_rem2[j-1] - s_dsh) : r_rem2[j-1];
            n_q1   = r_q1[j-1];
            n_q2   = r_q2[j-1];
            n_q1[BIT] = s_ge1;
            n_q2[BIT] = s_ge2;
        end

        always_ff @(posedge i_clk) begin
            if (adv) begin
                r_cry[j]  <= r_cry[j-1];
                r_den[j]  <= r_den[j-1];
                r_rem1[j] <= n_rem1;
                r_rem2[j] <= n_rem2;
                r_q1[j]   <= n_q1;
                r_q2[j]   <= n_q2;
            end
        end
    end

    // ---------------- output stage: hue wrap and level blend
    hcwm_pkg::t_carry s_c;
    logic [10:0]   s_hsum, s_hm1, s_hm2;
    logic [LW-1:0] s_f, s_fb, s_white, s_black;
    logic [7:0]    s_fa;
    logic [14:0]   s_wsum, s_bsum;

    always_comb begin
        s_c    = r_cry[hcwm_pkg::ST_DIVN];
        s_hsum = 11'(s_c.hue_b) + 11'(hcwm_pkg::FULL_ARC);
        s_hsum = s_c.neg ? (s_hsum - 11'(r_q1[hcwm_pkg::ST_DIVN]))
                         : (s_hsum + 11'(r_q1[hcwm_pkg::ST_DIVN]));
        // sum is below four full arcs
        s_hm1  = (s_hsum >= 11'(2 * hcwm_pkg::FULL_ARC)) ?
                 (s_hsum - 11'(2 * hcwm_pkg::FULL_ARC)) : s_hsum;
        s_hm2  = (s_hm1 >= 11'(hcwm_pkg::FULL_ARC)) ?
                 (s_hm1 - 11'(hcwm_pkg::FULL_ARC)) : s_hm1;
        s_f    = r_q2[hcwm_pkg::ST_DIVN][LW-1:0];
        s_fa   = {1'b0, s_f} + 8'd1;
        s_fb   = hcwm_pkg::LEVEL_MAX - s_f;
        s_wsum = 15'(s_c.white_a) * 15'(s_fa) + 15'(s_c.white_b) * 15'(s_fb);
        s_bsum = 15'(s_c.black_a) * 15'(s_fa) + 15'(s_c.black_b) * 15'(s_fb);
        s_white = s_wsum[13:7];
        s_black = s_bsum[13:7];
    end

    always_ff @(posedge i_clk) begin
        if (adv) begin
            r_mixed <= {s_hm2[HW-1:0], s_white, s_black, s_c.alpha};
            r_wout  <= s_c.weight;
        end
    end

    // ---------------- checks
    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.mixed_colour[30:22] < 9'(hcwm_pkg::FULL_ARC)))
        else $error("mixed hue out of range");

    a_weight_min: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out.valid |-> (o_out.weight_out >= 8'd2))
        else $error("weight out below two");

    a_rem_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[hcwm_pkg::ST_DIVN] |->
            (r_rem1[hcwm_pkg::ST_DIVN] < RW'(r_den[hcwm_pkg::ST_DIVN])))
        else $error("hue quotient overflowed divider");

    a_rem_level: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_vld[hcwm_pkg::ST_DIVN] |->
            (r_rem2[hcwm_pkg::ST_DIVN] < RW'(r_den[hcwm_pkg::ST_DIVN]) &&
             r_q2[hcwm_pkg::ST_DIVN] <= QW'(hcwm_pkg::LEVEL_MAX)))
        else $error("blend factor out of range");

endmodule

`default_nettype wire

@@ dv/hwb_colour_weighted_mix_core_tb.sv @@
// hwb_colour_weighted_mix_core_tb: directed and random stimulus, checked against a hwba mix predictor
`timescale 1ns / 100ps

module hwb_colour_weighted_mix_core_tb;

    localparam int HUE_W    = hcwm_pkg::HUE_W;
    localparam int LEVEL_W  = hcwm_pkg::LEVEL_W;
    localparam int ALPHA_W  = hcwm_pkg::ALPHA_W;
    localparam int WGT_W    = hcwm_pkg::WGT_W;
    localparam int COLOUR_W = hcwm_pkg::COLOUR_W;
    localparam int MIXED_W  = hcwm_pkg::MIXED_W;
    localparam logic [LEVEL_W-1:0] LEVEL_MAX = hcwm_pkg::LEVEL_MAX;

    localparam int ARC_FULL   = int'(hcwm_pkg::FULL_ARC);
    localparam int ARC_HALF   = int'(hcwm_pkg::HALF_ARC);
    localparam int LEVEL_TOP  = int'(hcwm_pkg::LEVEL_MAX);
    localparam int ALPHA_FULL = int'(hcwm_pkg::ALPHA_ONE);
    localparam int ALPHA_TOP  = (1 << ALPHA_W) - 1;
    localparam int WGT_TOP    = int'(hcwm_pkg::WGT_CAP);

    localparam int N_DIRECTED       = 22;
    localparam int RANDOM_BEATS     = 1030;
    localparam int QUIET_BEATS      = 150;
    localparam int PAUSE_AT         = 600;
    localparam int LONG_HOLD_AFTER  = 300;
    localparam int LONG_HOLD_CYCLES = 60;
    localparam int DRAIN_CYCLES     = 24;

    // packed hwba colour, msb unused on input and absent on output
    typedef struct packed {
        logic               spare;
        logic [HUE_W-1:0]   hue;
        logic [LEVEL_W-1:0] white;
        logic [LEVEL_W-1:0] black;
        logic [ALPHA_W-1:0] alpha;
    } t_hwba;

    typedef struct packed {
        logic [MIXED_W-1:0] mixed_colour;
        logic [WGT_W-1:0]   weight_out;
    } t_mix_result;

    typedef struct packed {
        logic [COLOUR_W-1:0] colour_a;
        logic [COLOUR_W-1:0] colour_b;
        logic [WGT_W-1:0]    weight_in;
        logic                typed;
        logic [MIXED_W-1:0]  exp_mixed;
        logic [WGT_W-1:0]    exp_weight;
    } t_directed_row;

    logic i_clk;
    logic i_rst_n;

    hcwm_in_if  in_ch ();
    hcwm_out_if out_ch ();

    hwb_colour_weighted_mix_core i_dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    t_mix_result mix_expected [$];
    t_mix_result arrived_want;
    int          mismatch_count = 0;
    int          results_taken  = 0;
    bit          quiet_tail     = 1'b0;

    // a, b, weight, typed, expected mixed colour, expected weight
    t_directed_row directed_rows [N_DIRECTED] = '{
        // all zero: both alphas zero and weight zero
        {32'h0, 32'h0, 8'd0, 1'b1, 31'd0, 8'd2},
        // opaque a against clear b at the weight cap returns a
        {{1'b0, 9'd100, 7'd50, 7'd20, 8'hFF}, {1'b0, 9'd200, 7'd10, 7'd90, 8'h00}, 8'd254,
         1'b1, {9'd100, 7'd50, 7'd20, 8'hFF}, 8'd254},
        // both alphas zero
        {{1'b0, 9'd10, 7'd64, 7'd0, 8'h00}, {1'b0, 9'd50, 7'd32, 7'd16, 8'h00}, 8'd7,
         1'b1, {9'd50, 7'd32, 7'd15, 8'h00}, 8'd8},
        // every bit set: both grey, hue field out of range
        {32'hFFFF_FFFF, 32'hFFFF_FFFF, 8'd255, 1'b1, {9'd151, 7'd127, 7'd127, 8'hFF}, 8'd255},
        {{1'b0, 9'd30, 7'd20, 7'd40, 8'hFF}, {1'b0, 9'd90, 7'd100, 7'd5, 8'hFF}, 8'd1,
         1'b0, 31'd0, 8'd0},
        {{1'b0, 9'd120, 7'd33, 7'd77, 8'h91}, {1'b0, 9'd45, 7'd101, 7'd2, 8'h3C}, 8'd253,
         1'b0, 31'd0, 8'd0},
        {{1'b0, 9'd300, 7'd0, 7'd126, 8'h01}, {1'b0, 9'd1, 7'd126, 7'd0, 8'hFE}, 8'd255,
         1'b0, 31'd0, 8'd0},
        // grey a by whiteness, by blackness
        {{1'b0, 9'd300, 7'd127, 7'd3, 8'h80}, {1'b0, 9'd20, 7'd10, 7'd10, 8'hC0}, 8'd5,
         1'b0, 31'd0, 8'd0},
        {{1'b0, 9'd300, 7'd3, 7'd127, 8'h80}, {1'b0, 9'd40, 7'd60, 7'd12, 8'h20}, 8'd9,
         1'b0, 31'd0, 8'd0},
        // grey b by whiteness, by blackness
        {{1'b0, 9'd77, 7'd15, 7'd25, 8'h40}, {1'b0, 9'd340, 7'd127, 7'd0, 8'h90}, 8'd3,
         1'b0, 31'd0, 8'd0},
        {{1'b0, 9'd210, 7'd90, 7'd8, 8'hE0}, {1'b0, 9'd5, 7'd0, 7'd127, 8'h11}, 8'd2,
         1'b0, 31'd0, 8'd0},
        // both grey
        {{1'b0, 9'd100, 7'd127, 7'd0, 8'h40}, {1'b0, 9'd250, 7'd0, 7'd127, 8'h90}, 8'd12,
         1'b0, 31'd0, 8'd0},
        // shorter arc across zero, both directions
        {{1'b0, 9'd350, 7'd40, 7'd40, 8'h70}, {1'b0, 9'd10, 7'd80, 7'd20, 8'hA0}, 8'd4,
         1'b0, 31'd0, 8'd0},
        {{1'b0, 9'd10, 7'd40, 7'd40, 8'h70}, {1'b0, 9'd350, 7'd80, 7'd20, 8'hA0}, 8'd4,
         1'b0, 31'd0, 8'd0},
        // hue difference exactly half a turn, and one past
        {{1'b0, 9'd0, 7'd11, 7'd22, 8'h55}, {1'b0, 9'd180, 7'd33, 7'd44, 8'h66}, 8'd6,
         1'b0, 31'd0, 8'd0},
        {{1'b0, 9'd0, 7'd11, 7'd22, 8'h55}, {1'b0, 9'd181, 7'd33, 7'd44, 8'h66}, 8'd6,
         1'b0, 31'd0, 8'd0},
        // hue fields above the circle
        {{1'b0, 9'd511, 7'd50, 7'd50, 8'hC8}, {1'b0, 9'd400, 7'd5, 7'd70, 8'h19}, 8'd100,
         1'b0, 31'd0, 8'd0},
        {{1'b0, 9'd360, 7'd60, 7'd6, 8'h7F}, {1'b0, 9'd0, 7'd6, 7'd60, 8'h80}, 8'd128,
         1'b0, 31'd0, 8'd0},
        // msb set on both colours
        {{1'b1, 9'd123, 7'd45, 7'd67, 8'h89}, {1'b1, 9'd234, 7'd56, 7'd78, 8'h9A}, 8'd17,
         1'b0, 31'd0, 8'd0},
        // clear a over visible b
        {{1'b0, 9'd200, 7'd100, 7'd1, 8'h00}, {1'b0, 9'd20, 7'd1, 7'd100, 8'hF0}, 8'd200,
         1'b0, 31'd0, 8'd0},
        // faint a over clear b with zero weight
        {{1'b0, 9'd270, 7'd70, 7'd30, 8'h01}, {1'b0, 9'd90, 7'd30, 7'd70, 8'h00}, 8'd0,
         1'b0, 31'd0, 8'd0},
        // just short of grey
        {{1'b0, 9'd359, 7'd126, 7'd126, 8'hAA}, {1'b0, 9'd1, 7'd126, 7'd126, 8'h55}, 8'd64,
         1'b0, 31'd0, 8'd0}
    };

    function automatic t_mix_result predict_mix(input t_hwba ca, input t_hwba cb,
                                                input logic [WGT_W-1:0] wgt_in);
        int          w, ha, hb, aa, ab, span, shift, delta, den;
        int          step, frac, hue_mix, white_mix, black_mix, alpha_mix;
        t_hwba       mixed;
        t_mix_result r;
        w  = (wgt_in == '0) ? 1 : int'(wgt_in);
        // a grey colour borrows the other hue
        ha = (ca.white == LEVEL_MAX || ca.black == LEVEL_MAX) ? int'(cb.hue) : int'(ca.hue);
        hb = (cb.white == LEVEL_MAX || cb.black == LEVEL_MAX) ? ha : int'(cb.hue);
        span  = (ha > hb) ? ha - hb : hb - ha;
        shift = (span > ARC_HALF) ? ARC_HALF : 0;
        delta = (ha + shift) % ARC_FULL - (hb + shift) % ARC_FULL;
        aa  = int'(ca.alpha);
        ab  = int'(cb.alpha);
        den = w * aa + ab;
        step = 0;
        frac = 0;
        if (den != 0) begin
            step = delta * w * aa / den;
            frac = LEVEL_TOP * w * aa / den;
        end
        hue_mix   = (hb + ARC_FULL + step) % ARC_FULL;
        white_mix = (int'(ca.white) * (frac + 1) + int'(cb.white) * (LEVEL_TOP - frac)) >> LEVEL_W;
        black_mix = (int'(ca.black) * (frac + 1) + int'(cb.black) * (LEVEL_TOP - frac)) >> LEVEL_W;
        alpha_mix = (ALPHA_FULL - (ALPHA_TOP - aa) * (ALPHA_TOP - ab)) >> ALPHA_W;
        mixed       = '0;
        mixed.hue   = hue_mix[HUE_W-1:0];
        mixed.white = white_mix[LEVEL_W-1:0];
        mixed.black = black_mix[LEVEL_W-1:0];
        mixed.alpha = alpha_mix[ALPHA_W-1:0];
        r.mixed_colour = mixed[MIXED_W-1:0];
        r.weight_out   = WGT_W'(w + ((w < WGT_TOP) ? 1 : 0));
        return r;
    endfunction

    function automatic t_hwba random_colour();
        t_hwba c;
        c = t_hwba'($urandom);
        case ($urandom_range(0, 11))
            0: c.white = LEVEL_MAX;
            1: c.black = LEVEL_MAX;
            2: c.alpha = '0;
            3: c.alpha = '1;
            4, 5: c.hue = HUE_W'($urandom_range(0, ARC_FULL - 1));
            default: ;
        endcase
        return c;
    endfunction

    function automatic logic [WGT_W-1:0] random_weight();
        case ($urandom_range(0, 7))
            0: return 8'd0;
            1: return 8'd1;
            2: return 8'd253;
            3: return 8'd254;
            4: return 8'd255;
            default: return WGT_W'($urandom_range(0, 255));
        endcase
    endfunction

    // after an optional random gap, hold the beat until taken, then queue what it should produce
    task automatic offer_beat(input t_hwba ca, input t_hwba cb, input logic [WGT_W-1:0] wgt,
                              input t_mix_result want, input bit allow_gap);
        if (allow_gap && $urandom_range(0, 4) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        in_ch.valid     <= 1'b1;
        in_ch.colour_a  <= ca;
        in_ch.colour_b  <= cb;
        in_ch.weight_in <= wgt;
        do @(posedge i_clk); while (!in_ch.ready);
        mix_expected.push_back(want);
    endtask

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        i_rst_n <= 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
    end

    initial begin : stimulus
        t_directed_row row;
        t_mix_result   want;
        t_hwba         ca, cb;
        logic [WGT_W-1:0] wgt;
        int            idx;
        in_ch.valid     <= 1'b0;
        in_ch.colour_a  <= '0;
        in_ch.colour_b  <= '0;
        in_ch.weight_in <= '0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        for (idx = 0; idx < N_DIRECTED; idx++) begin
            row = directed_rows[idx];
            if (row.typed)
                want = {row.exp_mixed, row.exp_weight};
            else
                want = predict_mix(row.colour_a, row.colour_b, row.weight_in);
            offer_beat(row.colour_a, row.colour_b, row.weight_in, want, 1'b1);
        end
        for (idx = 0; idx < RANDOM_BEATS; idx++) begin
            if (idx == PAUSE_AT) begin
                // let the pipe run dry before going on
                in_ch.valid <= 1'b0;
                while (mix_expected.size() != 0) @(posedge i_clk);
            end
            quiet_tail = (idx >= RANDOM_BEATS - QUIET_BEATS);
            ca  = random_colour();
            cb  = random_colour();
            wgt = random_weight();
            // steer some pairs near the half-turn boundary
            if ($urandom_range(0, 3) == 0)
                cb.hue = HUE_W'((ca.hue + $urandom_range(175, 185)) % ARC_FULL);
            offer_beat(ca, cb, wgt, predict_mix(ca, cb, wgt), !quiet_tail);
        end
        in_ch.valid <= 1'b0;
        while (mix_expected.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (mismatch_count == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

    initial begin : result_drain
        int  held;
        bit  long_hold_done;
        long_hold_done = 1'b0;
        out_ch.ready <= 1'b0;
        while (i_rst_n !== 1'b1) @(posedge i_clk);
        forever begin
            if (!long_hold_done && results_taken >= LONG_HOLD_AFTER) begin
                // long back-pressure so the pipe fills and input ready drops
                long_hold_done = 1'b1;
                out_ch.ready <= 1'b0;
                for (held = 0; held < LONG_HOLD_CYCLES; held++) @(posedge i_clk);
            end else if (!quiet_tail && $urandom_range(0, 4) == 0) begin
                out_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge i_clk);
            end
            out_ch.ready <= 1'b1;
            @(posedge i_clk);
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            results_taken++;
            if (mix_expected.size() == 0) begin
                $error("unexpected beat: mixed_colour %h weight_out %0d",
                       out_ch.mixed_colour, out_ch.weight_out);
                mismatch_count++;
            end else begin
                arrived_want = mix_expected.pop_front();
                if (out_ch.mixed_colour !== arrived_want.mixed_colour) begin
                    $error("mixed_colour: expected %h, got %h",
                           arrived_want.mixed_colour, out_ch.mixed_colour);
                    mismatch_count++;
                end
                if (out_ch.weight_out !== arrived_want.weight_out) begin
                    $error("weight_out: expected %0d, got %0d",
                           arrived_want.weight_out, out_ch.weight_out);
                    mismatch_count++;
                end
            end
        end
    end

    initial begin
        #500000;
        $display("TB_ERROR");
        $finish;
    end

endmodule
